/* src/itrt_pkg.sv */
// Shared types, constants and helpers for the integer-to-radix-text block.
package itrt_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int CHUNK_BITS    = 8;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;
  localparam logic [4:0] BASE_TEN = 5'd10;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A     = 8'h61;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_NUL   = 8'h00;

  // Classification of one word, passed from front to back
  typedef struct packed {
    logic       bad;
    logic       neg;
    logic [4:0] base;
  } itrt_cls_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_SHOW = 5'b10000
  } itrt_state_t;

  function automatic logic [7:0] ascii_of_digit(input logic [3:0] d);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = ASCII_ZERO + {4'd0, d};
    end else begin
      c = ASCII_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* src/integer_to_radix_text.sv */
// Integer-to-radix-text converter: top level with front, queue and back.
//
// Each input word (value, base, signed_mode) becomes its text in the given
// base, one ASCII character per output word, most significant digit first,
// with out_last on the final character. Digits above nine are lower-case
// letters. In signed mode with base ten a word with its top bit set is
// negated and a '-' goes out first. A base outside 2..16 gives one output
// word with character 0, out_last and out_bad_base set. The front checks the
// base and negates combinationally and pushes the word into a two-entry
// queue, so up to two words can wait while the back is busy. The back
// divides by the base with an 8-bit-per-cycle long division, one digit per
// pass over all chunks of the word; the digits go into a small RAM and are
// read back in reverse, each character through a read, a load and a show
// step, and the show step waits while the consumer holds out_ready low.
module integer_to_radix_text
  import itrt_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_value,
  input  logic [4:0]           in_base,
  input  logic                 in_signed_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_character,
  output logic                 out_last,
  output logic                 out_bad_base
);

  localparam int JOB_W = $bits(itrt_cls_t) + WORD_BITS;

  // Classified word from the front
  itrt_cls_t            f_cls;
  logic [WORD_BITS-1:0] f_mag;

  // Head of the queue toward the back
  logic                 q_valid;
  logic                 q_ready;
  logic [JOB_W-1:0]     q_data;
  itrt_cls_t            b_cls;
  logic [WORD_BITS-1:0] b_mag;

  itrt_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .in_value      (in_value),
    .in_base       (in_base),
    .in_signed_mode(in_signed_mode),
    .cls           (f_cls),
    .mag           (f_mag)
  );

  // Hold classified words until the back takes them
  itrt_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(in_valid),
    .wr_ready(in_ready),
    .wr_data ({f_cls, f_mag}),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_data)
  );

  assign b_cls = q_data[JOB_W-1 -: $bits(itrt_cls_t)];
  assign b_mag = q_data[WORD_BITS-1:0];

  // Divide, store digits and drive the output words
  itrt_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_valid),
    .job_ready    (q_ready),
    .job_cls      (b_cls),
    .job_mag      (b_mag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .out_bad_base (out_bad_base)
  );

  // A rejected base is always a lone NUL word that ends the text
  a_bad_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_base |-> out_last && (out_character == ASCII_NUL))
    else $error("bad-base word is not a lone NUL");

  // A minus sign never ends the text
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == ASCII_MINUS) |-> !out_last)
    else $error("minus sign marked last");

  // After a non-final character the next one needs a RAM read first
  a_gap_after_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !out_valid)
    else $error("character issued without digit read");

endmodule

/* src/itrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module itrt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/itrt_front.sv */
// Front end: check the base and fold a negative signed base-ten word.
module itrt_front
  import itrt_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic [WORD_BITS-1:0] in_value,
  input  logic [4:0]           in_base,
  input  logic                 in_signed_mode,
  output itrt_cls_t            cls,
  output logic [WORD_BITS-1:0] mag
);

  logic neg;

  assign neg = in_signed_mode && (in_base == BASE_TEN) && in_value[WORD_BITS-1];

  always_comb begin
    cls.bad  = (in_base < BASE_MIN) || (in_base > BASE_MAX);
    cls.neg  = neg;
    cls.base = in_base;
    mag      = neg ? (~in_value + WORD_BITS'(1)) : in_value;
  end

endmodule

/* src/itrt_queue.sv */
// Two-entry word queue between front and back.
module itrt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = ent_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/itrt_back.sv */
// Back end: digit extraction by chunked long division, then character output.
module itrt_back
  import itrt_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  itrt_cls_t            job_cls,
  input  logic [WORD_BITS-1:0] job_mag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_character,
  output logic                 out_last,
  output logic                 out_bad_base
);

  localparam int CHUNKS   = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_BITS = CHUNKS * CHUNK_BITS;
  localparam int CHUNK_CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W    = $clog2(WORD_BITS + 1);
  localparam int ADDR_W   = $clog2(WORD_BITS);

  itrt_state_t         state_r, state_nxt;
  logic [PAD_BITS-1:0] q_r, q_nxt, q_shift;
  logic [4:0]          base_r, base_nxt;
  logic                neg_r, neg_nxt;
  logic [3:0]          rem_r, rem_nxt, rem_step;
  logic [CHUNK_CW-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [7:0]          char_r, char_nxt;
  logic                last_r, last_nxt;
  logic                bad_r, bad_nxt;
  logic [CHUNK_BITS-1:0] top, qbits;
  logic [4:0]          trial;
  logic                ram_we;
  logic [3:0]          ram_rdata;

  itrt_ram #(
    .WIDTH(4),
    .DEPTH(WORD_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(rem_step),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  // One chunk of long division: narrow remainder, one quotient bit per step
  always_comb begin
    top      = q_r[PAD_BITS-1 -: CHUNK_BITS];
    rem_step = rem_r;
    qbits    = '0;
    trial    = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      trial = {rem_step, top[i]};
      if (trial >= base_r) begin
        trial    = trial - base_r;
        qbits[i] = 1'b1;
      end
      rem_step = trial[3:0];
    end
    q_shift = (q_r << CHUNK_BITS) | PAD_BITS'(qbits);
  end

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    bad_nxt   = bad_r;
    job_ready = 1'b0;
    ram_we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_ready = 1'b1;
          if (job_cls.bad) begin
            char_nxt  = ASCII_NUL;
            last_nxt  = 1'b1;
            bad_nxt   = 1'b1;
            state_nxt = ST_SHOW;
          end else begin
            q_nxt     = PAD_BITS'(job_mag);
            base_nxt  = job_cls.base;
            neg_nxt   = job_cls.neg;
            rem_nxt   = '0;
            chunk_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        q_nxt   = q_shift;
        rem_nxt = rem_step;
        if (chunk_r == CHUNK_CW'(CHUNKS - 1)) begin
          chunk_nxt = '0;
          rem_nxt   = '0;
          ram_we    = (cnt_r < CNT_W'(WORD_BITS));
          if (ram_we) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (q_shift == '0) begin
            idx_nxt = ADDR_W'(cnt_nxt - CNT_W'(1));
            if (neg_r) begin
              char_nxt  = ASCII_MINUS;
              last_nxt  = 1'b0;
              bad_nxt   = 1'b0;
              state_nxt = ST_SHOW;
            end else begin
              state_nxt = ST_RD;
            end
          end
        end else begin
          chunk_nxt = chunk_r + CHUNK_CW'(1);
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        char_nxt  = ascii_of_digit(ram_rdata);
        last_nxt  = (idx_r == '0);
        bad_nxt   = 1'b0;
        idx_nxt   = idx_r - ADDR_W'(1);
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_nxt = last_r ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    base_r  <= base_nxt;
    neg_r   <= neg_nxt;
    rem_r   <= rem_nxt;
    chunk_r <= chunk_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    bad_r   <= bad_nxt;
  end

  assign out_valid     = (state_r == ST_SHOW);
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_bad_base  = bad_r;

endmodule

/* sim/itrt_text_checker.sv */
// Checker for integer_to_radix_text: predicts each text word and compares it.
`timescale 1ns / 1ps

module itrt_text_checker
  import itrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_value,
  input  logic [4:0]  in_base,
  input  logic        in_signed_mode,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_character,
  input  logic        out_last,
  input  logic        out_bad_base,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       bad_base;
  } text_char_t;

  text_char_t expected_text[$];
  int         errors = 0;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    if (d < 4'd10) begin
      return {4'h3, d};
    end
    return ASCII_A + {4'd0, d - 4'd10};
  endfunction

  // Split the word into digits of the base and queue its characters.
  function automatic void predict_text(input logic [31:0] value, input logic [4:0] base,
                                       input logic sgn);
    logic [31:0] mag;
    logic [31:0] divisor;
    logic [31:0] rem;
    logic [3:0]  digits [32];
    logic        neg;
    int          nd;
    if (base < BASE_MIN || base > BASE_MAX) begin
      expected_text.push_back('{ASCII_NUL, 1'b1, 1'b1});
      return;
    end
    neg     = sgn && (base == BASE_TEN) && value[31];
    mag     = neg ? (32'd0 - value) : value;
    divisor = {27'd0, base};
    nd      = 0;
    do begin
      rem        = mag % divisor;
      digits[nd] = rem[3:0];
      nd++;
      mag        = mag / divisor;
    end while (mag != 32'd0);
    if (neg) begin
      expected_text.push_back('{ASCII_MINUS, 1'b0, 1'b0});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      expected_text.push_back('{digit_glyph(digits[i]), i == 0, 1'b0});
    end
  endfunction

  // Check the output word first so a word accepted at the same edge cannot match it.
  always @(posedge clk) begin
    text_char_t exp_char;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected output word: character %h last %b bad_base %b",
                 out_character, out_last, out_bad_base);
          errors++;
        end else begin
          exp_char = expected_text.pop_front();
          if (out_character !== exp_char.character) begin
            $error("character: expected %h, got %h", exp_char.character, out_character);
            errors++;
          end
          if (out_last !== exp_char.last) begin
            $error("last: expected %b, got %b", exp_char.last, out_last);
            errors++;
          end
          if (out_bad_base !== exp_char.bad_base) begin
            $error("bad_base: expected %b, got %b", exp_char.bad_base, out_bad_base);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_text(in_value, in_base, in_signed_mode);
      end
    end
    pending_words <= expected_text.size();
    fail_count    <= errors;
  end

endmodule

/* sim/tb_integer_to_radix_text.sv */
// Testbench top for integer_to_radix_text: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_integer_to_radix_text
  import itrt_pkg::*;
();

  localparam int RANDOM_WORDS = 360;
  localparam int IDLE_LIMIT   = 5000;  // cycles with no word accepted on either side
  localparam int LONG_HOLD    = 400;   // receiver hold-off that backs up the input
  localparam int TAIL_CYCLES  = 300;   // settle time after the last expected word

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_value;
  logic [4:0]  in_base;
  logic        in_signed_mode;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_character;
  logic        out_last;
  logic        out_bad_base;

  int   fail_count;
  int   pending_words;
  int   idle_cycles = 0;
  logic idle_on     = 1'b1;   // random bursts of idling on both sides
  logic hold_req    = 1'b0;   // ask the receiver for one long hold-off

  integer_to_radix_text DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_base        (in_base),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .out_bad_base   (out_bad_base)
  );

  itrt_text_checker u_text_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_base        (in_base),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .out_bad_base   (out_bad_base),
    .fail_count     (fail_count),
    .pending_words  (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one input word; hold valid and payload until the block takes it.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_word(input logic [31:0] value, input logic [4:0] base,
                           input logic sgn);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_base        <= base;
    in_signed_mode <= sgn;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted character has come out.
  task automatic drain_text();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Half of the words are small so that conversions stay short; a share of full
  // 32-bit words and corner values keeps the wide cases in play.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 255);
      3, 4:    return $urandom_range(0, 65535);
      5:       begin
        case ($urandom_range(0, 5))
          0:       return 32'h0000_0000;
          1:       return 32'hffff_ffff;
          2:       return 32'h8000_0000;
          3:       return 32'h7fff_ffff;
          4:       return 32'h8000_0001;
          default: return 32'd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] pick_base();
    case ($urandom_range(0, 9))
      0, 1:    return BASE_TEN;                 // signed mode only matters here
      2, 3:    return 5'($urandom_range(0, 31)); // any code, bad bases included
      default: return 5'($urandom_range(2, 16));
    endcase
  endfunction

  // Receiver: random ready bursts, one long hold-off on request, steady at the end.
  initial begin
    logic stall;
    logic held;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = idle_on && ($urandom_range(0, 2) == 0);
        out_ready <= !stall;
        if (stall) begin
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_integer_to_radix_text: done, errors");
    $finish;
  end

  initial begin
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_base        <= '0;
    in_signed_mode <= 1'b0;
    rst_n          <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: zero, widest text, letters, sign handling, rejected bases.
    send_word(32'h0000_0000, BASE_TEN, 1'b0);
    send_word(32'h0000_0000, 5'd2,     1'b1);
    send_word(32'hffff_ffff, 5'd2,     1'b0);  // 32 digits, the longest text
    send_word(32'hffff_ffff, BASE_MAX, 1'b0);
    send_word(32'hdead_beef, BASE_MAX, 1'b1);  // signed flag ignored off base ten
    send_word(32'hffff_ffff, BASE_TEN, 1'b0);
    send_word(32'hffff_ffff, BASE_TEN, 1'b1);  // minus one
    send_word(32'h8000_0000, BASE_TEN, 1'b1);  // most negative word stays put
    send_word(32'h8000_0000, BASE_TEN, 1'b0);
    send_word(32'h7fff_ffff, BASE_TEN, 1'b1);
    send_word(32'h8000_0000, 5'd8,     1'b1);
    send_word(32'h1234_5678, 5'd0,     1'b0);  // rejected bases
    send_word(32'h1234_5678, 5'd1,     1'b1);
    send_word(32'hffff_ffff, 5'd17,    1'b0);
    send_word(32'h0000_0000, 5'd31,    1'b1);
    send_word(32'd12345,     5'd3,     1'b0);
    send_word(32'd777,       5'd7,     1'b1);
    send_word(32'hffff_fffe, 5'd12,    1'b0);
    send_word(32'd224,       5'd15,    1'b0);
    send_word(32'd35,        5'd11,    1'b0);
    send_word(32'd1,         5'd13,    1'b1);
    send_word(32'd9,         5'd9,     1'b0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      // Hold the receiver off while words keep coming, to back up the input.
      if (k == 100) begin
        hold_req = 1'b1;
      end
      // Pause the sender until the output side has caught up.
      if (k == 200) begin
        drain_text();
      end
      // Run the last stretch with no idling on either side.
      if (k == RANDOM_WORDS - 40) begin
        idle_on = 1'b0;
      end
      send_word(pick_value(), pick_base(), 1'($urandom_range(0, 1)));
    end

    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_integer_to_radix_text: done, clean");
    end else begin
      $display("tb_integer_to_radix_text: done, errors");
    end
    $finish;
  end

endmodule
